// ===== hw/rtl/mphw_pkg.sv =====
// Shared constants and codes for the peak-hold window meter.
package mphw_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int LEVEL_BITS_DEF  = 16;
  localparam int TIME_BITS       = 32;
  localparam int WINDOW_BITS     = 16;

  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd1000;
  localparam int FLOOR_RESET = -15360;

  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_RESET      = 2'd1,
    KIND_CLEAR_CLIP = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_WINDOW_MS   = 1'b0,
    CFG_FLOOR_LEVEL = 1'b1
  } cfg_index_t;

endpackage

// ===== hw/rtl/mphw_store.sv =====
// Window store: single-port-write, single-port-read RAM with registered read data.
module mphw_store #(
  parameter int DEPTH = mphw_pkg::STORE_DEPTH_DEF,
  parameter int WIDTH = mphw_pkg::TIME_BITS + mphw_pkg::LEVEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/mphw_scan.sv =====
// Expiry scan: sweeps the ring store, compacts survivors, appends the new entry, finds the peak.
module mphw_scan #(
  parameter int STORE_DEPTH = mphw_pkg::STORE_DEPTH_DEF,
  parameter int LEVEL_BITS  = mphw_pkg::LEVEL_BITS_DEF,
  localparam int IDX_W = $clog2(STORE_DEPTH),
  localparam int CNT_W = $clog2(STORE_DEPTH + 1),
  localparam int MEM_W = mphw_pkg::TIME_BITS + LEVEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [IDX_W-1:0]                    head,
  input  logic [CNT_W-1:0]                    count,
  input  logic signed [LEVEL_BITS-1:0]        lvl,
  input  logic [mphw_pkg::TIME_BITS-1:0]      now,
  input  logic [mphw_pkg::WINDOW_BITS-1:0]    win,
  output logic                                done,
  output logic [CNT_W-1:0]                    done_count,
  output logic signed [LEVEL_BITS-1:0]        done_peak,
  output logic                                busy,
  output logic                                mem_rd_en,
  output logic [IDX_W-1:0]                    mem_rd_addr,
  input  logic [MEM_W-1:0]                    mem_rd_data,
  output logic                                mem_wr_en,
  output logic [IDX_W-1:0]                    mem_wr_addr,
  output logic [MEM_W-1:0]                    mem_wr_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINAL} scan_state_t;

  scan_state_t                       state;
  logic signed [LEVEL_BITS-1:0]      lvl_r;
  logic [mphw_pkg::TIME_BITS-1:0]    now_r;
  logic [mphw_pkg::WINDOW_BITS-1:0]  win_r;
  logic [IDX_W-1:0]                  rd_ptr;
  logic [IDX_W-1:0]                  dst_ptr;
  logic [CNT_W-1:0]                  issue_left;
  logic [CNT_W-1:0]                  kept;
  logic signed [LEVEL_BITS-1:0]      best;
  logic                              pend;

  logic [IDX_W-1:0]                  rd_ptr_inc;
  logic [IDX_W-1:0]                  dst_ptr_inc;
  logic [mphw_pkg::TIME_BITS-1:0]    rd_time;
  logic signed [LEVEL_BITS-1:0]      rd_level;
  logic [mphw_pkg::TIME_BITS-1:0]    age;
  logic                              keep;

  assign rd_ptr_inc  = (rd_ptr == IDX_W'(STORE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign dst_ptr_inc = (dst_ptr == IDX_W'(STORE_DEPTH - 1)) ? '0 : dst_ptr + 1'b1;

  assign rd_time  = mem_rd_data[MEM_W-1:LEVEL_BITS];
  assign rd_level = mem_rd_data[LEVEL_BITS-1:0];
  assign age      = now_r - rd_time;
  // entries stamped ahead of now (negative age) are kept
  assign keep     = age[mphw_pkg::TIME_BITS-1] ||
                    (age <= {{(mphw_pkg::TIME_BITS - mphw_pkg::WINDOW_BITS){1'b0}}, win_r});

  assign mem_rd_en   = (state == S_SCAN) && (issue_left != '0);
  assign mem_rd_addr = rd_ptr;

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = dst_ptr;
    mem_wr_data = mem_rd_data;
    if (state == S_SCAN && pend && keep) begin
      mem_wr_en = 1'b1;
    end else if (state == S_FINAL) begin
      mem_wr_en   = 1'b1;
      mem_wr_data = {now_r, lvl_r};
    end
  end

  assign done       = (state == S_FINAL);
  assign done_count = kept + 1'b1;
  assign done_peak  = best;
  assign busy       = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (start) begin
            lvl_r      <= lvl;
            now_r      <= now;
            win_r      <= win;
            rd_ptr     <= head;
            dst_ptr    <= head;
            issue_left <= count;
            kept       <= '0;
            best       <= lvl;
            state      <= (count == '0) ? S_FINAL : S_SCAN;
          end
        end
        S_SCAN: begin
          pend <= (issue_left != '0);
          if (issue_left != '0) begin
            rd_ptr     <= rd_ptr_inc;
            issue_left <= issue_left - 1'b1;
          end
          if (pend && keep) begin
            dst_ptr <= dst_ptr_inc;
            kept    <= kept + 1'b1;
            if (rd_level > best) begin
              best <= rd_level;
            end
          end
          if (issue_left == '0) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          pend  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/meter_peak_hold_window_unit.sv =====
// Top level of the sliding-window peak-hold level meter.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------------
//  sample   | sample_valid / sample_stall | kind, level, time_ms
//  result   | result_valid / result_stall | recent_peak, max_peak, clip_flag, held_count
//  config   | cfg_write                   | cfg_index, cfg_data
//
// A sample that changes the level sweeps every entry held before it (a full store drops its
// oldest entry first) through the window store's one read port, an entry a cycle.
// Any other item skips the sweep. One item is worked on at a time; the next transfer is
// taken while the previous result waits in the output register.
// Reset is synchronous; the store needs no clearing pass and the block is ready at once.
// A stalled result holds the finished item back until the output register frees.
module meter_peak_hold_window_unit #(
  parameter int STORE_DEPTH = mphw_pkg::STORE_DEPTH_DEF,
  parameter int LEVEL_BITS  = mphw_pkg::LEVEL_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                cfg_write,
  input  logic                                                cfg_index,
  input  logic [((LEVEL_BITS > 16) ? LEVEL_BITS : 16)-1:0]    cfg_data,
  input  logic                                                sample_valid,
  output logic                                                sample_stall,
  input  logic [1:0]                                          kind,
  input  logic signed [LEVEL_BITS-1:0]                        level,
  input  logic [mphw_pkg::TIME_BITS-1:0]                      time_ms,
  output logic                                                result_valid,
  input  logic                                                result_stall,
  output logic signed [LEVEL_BITS-1:0]                        recent_peak,
  output logic signed [LEVEL_BITS-1:0]                        max_peak,
  output logic                                                clip_flag,
  output logic [$clog2(STORE_DEPTH + 1)-1:0]                  held_count
);

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int MEM_W = mphw_pkg::TIME_BITS + LEVEL_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_POST} top_state_t;

  top_state_t                        state;
  logic [mphw_pkg::WINDOW_BITS-1:0]  window_ms;
  logic signed [LEVEL_BITS-1:0]      floor_level;
  logic [IDX_W-1:0]                  head;
  logic [CNT_W-1:0]                  count;
  logic signed [LEVEL_BITS-1:0]      running_max;
  logic signed [LEVEL_BITS-1:0]      window_peak;
  logic signed [LEVEL_BITS-1:0]      last_level;
  logic                              clip_latch;

  logic                              sample_accept;
  logic                              is_new;
  logic                              full;
  logic [IDX_W-1:0]                  head_next;
  logic [CNT_W-1:0]                  count_next;
  logic                              out_free;

  logic                              scan_start;
  logic                              scan_done;
  logic                              scan_busy;
  logic [CNT_W-1:0]                  scan_count;
  logic signed [LEVEL_BITS-1:0]      scan_peak;
  logic                              mem_rd_en;
  logic [IDX_W-1:0]                  mem_rd_addr;
  logic [MEM_W-1:0]                  mem_rd_data;
  logic                              mem_wr_en;
  logic [IDX_W-1:0]                  mem_wr_addr;
  logic [MEM_W-1:0]                  mem_wr_data;

  assign sample_stall  = (state != ST_IDLE);
  assign sample_accept = sample_valid && !sample_stall;
  assign is_new        = (kind == mphw_pkg::KIND_SAMPLE) && (level != last_level);
  assign scan_start    = sample_accept && is_new;
  assign out_free      = !result_valid || !result_stall;

  // full store: oldest entry goes before the new one is added
  assign full       = (count == CNT_W'(STORE_DEPTH));
  assign head_next  = !full ? head :
                      (head == IDX_W'(STORE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign count_next = full ? CNT_W'(STORE_DEPTH - 1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms   <= mphw_pkg::WINDOW_RESET;
      floor_level <= LEVEL_BITS'(mphw_pkg::FLOOR_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        mphw_pkg::CFG_WINDOW_MS:   window_ms   <= cfg_data[mphw_pkg::WINDOW_BITS-1:0];
        mphw_pkg::CFG_FLOOR_LEVEL: floor_level <= cfg_data[LEVEL_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head         <= '0;
      count        <= '0;
      running_max  <= LEVEL_BITS'(mphw_pkg::FLOOR_RESET);
      window_peak  <= LEVEL_BITS'(mphw_pkg::FLOOR_RESET);
      last_level   <= LEVEL_BITS'(mphw_pkg::FLOOR_RESET);
      clip_latch   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_POST && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_accept) begin
            state <= ST_POST;
            priority if (is_new) begin
              head       <= head_next;
              count      <= count_next;
              last_level <= level;
              if (level > running_max) begin
                running_max <= level;
              end
              if (!level[LEVEL_BITS-1]) begin
                clip_latch <= 1'b1;
              end
              state <= ST_SCAN;
            end else if (kind == mphw_pkg::KIND_RESET) begin
              head        <= '0;
              count       <= '0;
              running_max <= floor_level;
              window_peak <= floor_level;
              last_level  <= floor_level;
            end else if (kind == mphw_pkg::KIND_CLEAR_CLIP) begin
              clip_latch <= 1'b0;
            end else begin
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            count       <= scan_count;
            window_peak <= scan_peak;
            state       <= ST_POST;
          end
        end
        ST_POST: begin
          if (out_free) begin
            recent_peak  <= window_peak;
            max_peak     <= running_max;
            clip_flag    <= clip_latch;
            held_count   <= count;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  mphw_scan #(
    .STORE_DEPTH (STORE_DEPTH),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .head        (head_next),
    .count       (count_next),
    .lvl         (level),
    .now         (time_ms),
    .win         (window_ms),
    .done        (scan_done),
    .done_count  (scan_count),
    .done_peak   (scan_peak),
    .busy        (scan_busy),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  mphw_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (MEM_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STORE_DEPTH))
    else $error("entry count beyond store depth");

  a_scan_owned: assert property (@(posedge clk) disable iff (rst)
    scan_busy |-> (state == ST_SCAN))
    else $error("scan running outside scan state");

  a_plain_item: assert property (@(posedge clk) disable iff (rst)
    (sample_accept && !is_new) |=> (state == ST_POST) && !scan_busy)
    else $error("non-changing item started a scan");
`endif

endmodule

// ===== tb/meter_peak_hold_window_checker.sv =====
// Checker for the peak-hold window meter: tracks the meter state and compares every reading.
`timescale 1ns / 100ps

module meter_peak_hold_window_checker #(
  parameter int STORE_DEPTH = mphw_pkg::STORE_DEPTH_DEF,
  parameter int LEVEL_BITS  = mphw_pkg::LEVEL_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             cfg_write,
  input  logic                                             cfg_index,
  input  logic [((LEVEL_BITS > 16) ? LEVEL_BITS : 16)-1:0] cfg_data,
  input  logic                                             sample_valid,
  input  logic                                             sample_stall,
  input  logic [1:0]                                       kind,
  input  logic signed [LEVEL_BITS-1:0]                     level,
  input  logic [mphw_pkg::TIME_BITS-1:0]                   time_ms,
  input  logic                                             result_valid,
  input  logic                                             result_stall,
  input  logic signed [LEVEL_BITS-1:0]                     recent_peak,
  input  logic signed [LEVEL_BITS-1:0]                     max_peak,
  input  logic                                             clip_flag,
  input  logic [$clog2(STORE_DEPTH + 1)-1:0]               held_count,
  output int                                               fail_count,
  output int                                               pending
);

  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int TIME_W = mphw_pkg::TIME_BITS;
  localparam int WIN_W  = mphw_pkg::WINDOW_BITS;

  typedef struct {
    logic signed [LEVEL_BITS-1:0] recent;
    logic signed [LEVEL_BITS-1:0] peak;
    logic                         clip;
    logic [CNT_W-1:0]             held;
  } meter_reading_t;

  meter_reading_t readings_due[$];

  logic signed [LEVEL_BITS-1:0] ring_level [STORE_DEPTH];
  logic [TIME_W-1:0]            ring_time  [STORE_DEPTH];
  int                           ring_head;
  int                           ring_fill;
  logic signed [LEVEL_BITS-1:0] top_level;
  logic signed [LEVEL_BITS-1:0] window_top;
  logic signed [LEVEL_BITS-1:0] prev_level;
  logic                         clip_seen;
  logic [WIN_W-1:0]             win_len;
  logic signed [LEVEL_BITS-1:0] floor_lvl;

  function automatic void wipe_meter();
    ring_head  = 0;
    ring_fill  = 0;
    top_level  = floor_lvl;
    window_top = floor_lvl;
    prev_level = floor_lvl;
  endfunction

  // new level goes in at the tail, stale entries are squeezed out, peak rescanned
  function automatic void log_level(input logic signed [LEVEL_BITS-1:0] lvl,
                                    input logic [TIME_W-1:0] now);
    int kept;
    int src;
    int dst;
    logic [TIME_W-1:0] age;
    logic signed [LEVEL_BITS-1:0] best;
    prev_level = lvl;
    if (ring_fill >= STORE_DEPTH) begin
      ring_head = (ring_head + 1) % STORE_DEPTH;
      ring_fill = STORE_DEPTH - 1;
    end
    dst = (ring_head + ring_fill) % STORE_DEPTH;
    ring_level[dst] = lvl;
    ring_time[dst]  = now;
    ring_fill++;
    kept = 0;
    for (int k = 0; k < ring_fill; k++) begin
      src = (ring_head + k) % STORE_DEPTH;
      age = now - ring_time[src];
      if (age[TIME_W-1] || age <= TIME_W'(win_len)) begin
        dst = (ring_head + kept) % STORE_DEPTH;
        ring_level[dst] = ring_level[src];
        ring_time[dst]  = ring_time[src];
        kept++;
      end
    end
    ring_fill = kept;
    best = floor_lvl;
    for (int k = 0; k < ring_fill; k++) begin
      src = (ring_head + k) % STORE_DEPTH;
      if (k == 0 || ring_level[src] > best) best = ring_level[src];
    end
    window_top = best;
    if (lvl > top_level) top_level = lvl;
    if (!lvl[LEVEL_BITS-1]) clip_seen = 1'b1;
  endfunction

  function automatic void check_field(input string what, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      if (fail_count < 10) $display("%s mismatch: expected %0d, got %0d", what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    meter_reading_t want;
    meter_reading_t due;
    if (rst) begin
      win_len   = mphw_pkg::WINDOW_RESET;
      floor_lvl = LEVEL_BITS'(mphw_pkg::FLOOR_RESET);
      clip_seen = 1'b0;
      wipe_meter();
      readings_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (readings_due.size() == 0) begin
          if (fail_count < 10) $display("reading transfer with none outstanding");
          fail_count++;
        end else begin
          want = readings_due.pop_front();
          check_field("recent_peak", 32'(want.recent), 32'(recent_peak));
          check_field("max_peak", 32'(want.peak), 32'(max_peak));
          check_field("clip_flag", 32'(want.clip), 32'(clip_flag));
          check_field("held_count", 32'(want.held), 32'(held_count));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          mphw_pkg::CFG_WINDOW_MS:   win_len = cfg_data[WIN_W-1:0];
          mphw_pkg::CFG_FLOOR_LEVEL: floor_lvl = cfg_data[LEVEL_BITS-1:0];
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        case (kind)
          mphw_pkg::KIND_SAMPLE:     if (level != prev_level) log_level(level, time_ms);
          mphw_pkg::KIND_RESET:      wipe_meter();
          mphw_pkg::KIND_CLEAR_CLIP: clip_seen = 1'b0;
          default: ;
        endcase
        due = '{window_top, top_level, clip_seen, CNT_W'(ring_fill)};
        readings_due = {readings_due, due};
      end
    end
    pending = readings_due.size();
  end

endmodule

// ===== tb/meter_peak_hold_window_unit_test.sv =====
// Testbench top for the peak-hold window meter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module meter_peak_hold_window_unit_test;

  localparam int STORE_DEPTH = mphw_pkg::STORE_DEPTH_DEF;
  localparam int LEVEL_BITS  = mphw_pkg::LEVEL_BITS_DEF;
  localparam int TIME_W      = mphw_pkg::TIME_BITS;
  localparam int WIN_W       = mphw_pkg::WINDOW_BITS;
  localparam int CFG_W       = (LEVEL_BITS > 16) ? LEVEL_BITS : 16;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int PHASE_ITEMS = 256;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 600;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write = 1'b0;
  logic                         cfg_index = mphw_pkg::CFG_WINDOW_MS;
  logic [CFG_W-1:0]             cfg_data = '0;
  logic                         sample_valid = 1'b0;
  logic                         sample_stall;
  logic [1:0]                   kind = mphw_pkg::KIND_SAMPLE;
  logic signed [LEVEL_BITS-1:0] level = '0;
  logic [TIME_W-1:0]            time_ms = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic signed [LEVEL_BITS-1:0] recent_peak;
  logic signed [LEVEL_BITS-1:0] max_peak;
  logic                         clip_flag;
  logic [CNT_W-1:0]             held_count;

  int check_fails;
  int check_pending;
  int sent_count = 0;
  int got_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit held_off = 1'b0;
  bit calm_out = 1'b0;
  bit calm_in = 1'b0;
  logic signed [LEVEL_BITS-1:0] prev_sent = '0;
  logic [TIME_W-1:0]            now_ms = '0;

  meter_peak_hold_window_unit i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .sample_valid, .sample_stall, .kind, .level, .time_ms,
    .result_valid, .result_stall, .recent_peak, .max_peak, .clip_flag, .held_count
  );

  meter_peak_hold_window_checker i_meter_check (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .sample_valid, .sample_stall, .kind, .level, .time_ms,
    .result_valid, .result_stall, .recent_peak, .max_peak, .clip_flag, .held_count,
    .fail_count(check_fails), .pending(check_pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // reading side: random stalls, calm stretches, and one long hold-off
  always @(posedge clk) begin : reader
    int h;
    int s;
    if (rst) begin
      got_count    <= 0;
      hold_left    <= 0;
      stall_left   <= 0;
      held_off     <= 1'b0;
      calm_out     <= 1'b0;
      result_stall <= 1'b0;
    end else begin
      h = hold_left;
      s = stall_left;
      if (result_valid && !result_stall) got_count <= got_count + 1;
      if (!held_off && got_count >= HOLD_AFTER) begin
        h = HOLD_CYCLES;
        held_off <= 1'b1;
      end
      if (s == 0 && !calm_out && $urandom_range(0, 4) == 0)
        s = ($urandom_range(0, 15) == 0) ? int'($urandom_range(10, 80))
                                         : int'($urandom_range(1, 3));
      if (cycle_count % 512 == 0) calm_out <= ($urandom_range(0, 3) == 0);
      result_stall <= (h != 0) || (s != 0);
      hold_left    <= (h != 0) ? h - 1 : 0;
      stall_left   <= (s != 0) ? s - 1 : 0;
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [LEVEL_BITS-1:0] l,
                           input logic [TIME_W-1:0] t);
    int pick;
    int gap;
    gap = 0;
    if (!calm_in) begin
      pick = int'($urandom_range(0, 99));
      if (pick >= 95) gap = int'($urandom_range(10, 60));
      else if (pick >= 60) gap = int'($urandom_range(1, 3));
    end
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    kind         <= k;
    level        <= l;
    time_ms      <= t;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (got_count != sent_count) @(posedge clk);
  endtask

  // registers change only with the meter idle; a reset item then loads the new floor
  task automatic program_meter(input logic [WIN_W-1:0] w,
                               input logic [LEVEL_BITS-1:0] f);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= mphw_pkg::CFG_WINDOW_MS;
    cfg_data  <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= mphw_pkg::CFG_FLOOR_LEVEL;
    cfg_data  <= CFG_W'(f);
    @(posedge clk);
    cfg_write <= 1'b0;
    send_item(mphw_pkg::KIND_RESET, LEVEL_BITS'($urandom()), $urandom());
  endtask

  task automatic run_phase(input int step_max);
    int pick;
    logic [1:0] k;
    logic signed [LEVEL_BITS-1:0] l;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n % 64 == 0) calm_in = ($urandom_range(0, 3) == 0);
      pick = int'($urandom_range(0, 99));
      if (pick < 4) k = mphw_pkg::KIND_RESET;
      else if (pick < 8) k = mphw_pkg::KIND_CLEAR_CLIP;
      else if (pick < 10) k = KIND_SPARE;
      else k = mphw_pkg::KIND_SAMPLE;
      if (k == mphw_pkg::KIND_SAMPLE) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 10) l = prev_sent;
        else if (pick < 25) l = LEVEL_BITS'($urandom());
        else l = LEVEL_BITS'(int'($urandom_range(0, 17920)) - 15360);
        pick = int'($urandom_range(0, 99));
        if (pick < 3) now_ms = now_ms - $urandom_range(1, 4 * step_max);
        else if (pick < 5) now_ms = $urandom();
        else now_ms = now_ms + $urandom_range(0, step_max);
        prev_sent = l;
        send_item(k, l, now_ms);
      end else begin
        send_item(k, LEVEL_BITS'($urandom()), $urandom());
      end
    end
  endtask

  initial begin : stimulus
    int w;
    int f;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // floor level repeated, extremes, clip at exactly 0 dB
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(-15360), 32'd100);
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(32767), 32'd100);
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(-32768), 32'd150);
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(-32768), 32'd160);
    send_item(mphw_pkg::KIND_CLEAR_CLIP, LEVEL_BITS'($urandom()), $urandom());
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(-1), 32'd200);
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(0), 32'd300);
    // expiry and the window edge
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(-256), 32'd1400);
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(-512), 32'd2400);
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(-768), 32'd2401);
    // time going backwards keeps the newer entries
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(-1024), 32'd1000);
    send_item(KIND_SPARE, LEVEL_BITS'($urandom()), $urandom());
    send_item(mphw_pkg::KIND_RESET, LEVEL_BITS'(0), 32'd0);
    // timestamp wrap and entries half a range apart
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(1024), 32'hFFFF_FF00);
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(2048), 32'h0000_0100);
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(3072), 32'h8000_0100);
    send_item(mphw_pkg::KIND_SAMPLE, LEVEL_BITS'(-2048), 32'h8000_0500);
    send_item(mphw_pkg::KIND_CLEAR_CLIP, LEVEL_BITS'($urandom()), $urandom());
    send_item(mphw_pkg::KIND_RESET, LEVEL_BITS'($urandom()), $urandom());

    now_ms = $urandom();
    run_phase(20);
    program_meter(16'd0, LEVEL_BITS'(-32768));
    run_phase(2);
    program_meter(16'hFFFF, '0);
    run_phase(1365);
    w = int'($urandom_range(1, 4000));
    f = 0 - int'($urandom_range(0, 32768));
    program_meter(WIN_W'(w), LEVEL_BITS'(f));
    run_phase(w / 48 + 1);
    program_meter(mphw_pkg::WINDOW_RESET, LEVEL_BITS'(mphw_pkg::FLOOR_RESET));
    run_phase(20);

    drain_results();
    repeat (STORE_DEPTH + 8) @(posedge clk);
    if (check_fails == 0 && check_pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
